FILE: hw/rtl/py411_pkg.sv
// Package for the packed YUV 4:1:1 to RGB converter.
// Holds the group record, the Q12 coefficients and the pixel clip function.
// No dependencies.
package py411_pkg;

    localparam int LumaW   = 8;
    localparam int ChromaW = 8;
    localparam int CoefW   = 14;
    localparam int TermW   = ChromaW + CoefW;       // chroma times coefficient
    localparam int SumW    = TermW + 2;             // luma*4096 + term + round
    localparam int QShift  = 12;
    localparam int NumLuma = 4;
    localparam int PixIdxW = $clog2(NumLuma);
    localparam int QDepth  = 2;
    localparam int QAddrW  = $clog2(QDepth);
    localparam int QCntW   = $clog2(QDepth + 1);
    localparam int InDataW  = 48;
    localparam int OutDataW = 24;

    localparam logic signed [CoefW-1:0] KRv = 14'sd5743;
    localparam logic signed [CoefW-1:0] KGu = 14'sd1411;
    localparam logic signed [CoefW-1:0] KGv = 14'sd2925;
    localparam logic signed [CoefW-1:0] KBu = 14'sd7258;
    localparam logic signed [SumW-1:0]  QRound = 24'sd2048;

    localparam logic [PixIdxW-1:0] LastFull = 2'd3;
    localparam logic [PixIdxW-1:0] LastHalf = 2'd1;

    typedef logic signed [TermW-1:0] t_term;

    // One group after chroma scaling, as it waits for the pixel sequencer.
    typedef struct packed {
        t_term                   term_r;
        t_term                   term_g;
        t_term                   term_b;
        logic [NumLuma-1:0][LumaW-1:0] luma;
        logic                    half;
    } t_group;

    // Floor shift by 12, then clip to 0..255.
    function automatic logic [7:0] clip_q12(input logic signed [SumW-1:0] sum);
        logic signed [SumW-QShift-1:0] q;
        q = sum[SumW-1:QShift];
        if (q[SumW-QShift-1]) begin
            return 8'd0;
        end else if (q[SumW-QShift-2:8] != '0) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

FILE: hw/rtl/py411_front.sv
// Front end: accepts packed groups and scales the shared chroma once per group.
// Depends on py411_pkg.
module py411_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [py411_pkg::InDataW-1:0] i_s_axis_tdata,
    input  logic                          i_half_width,
    output logic                          o_grp_valid,
    input  logic                          i_grp_ready,
    output py411_pkg::t_group             o_grp
);
    import py411_pkg::*;

    logic   r_valid;
    t_group r_grp;
    t_group n_grp;
    logic   accept;

    logic signed [ChromaW-1:0] u;
    logic signed [ChromaW-1:0] v;

    assign u = i_s_axis_tdata[7:0];
    assign v = i_s_axis_tdata[23:16];

    assign o_s_axis_tready = !r_valid || i_grp_ready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_grp.term_r  = TermW'(v) * TermW'(KRv);
        n_grp.term_g  = -(TermW'(u) * TermW'(KGu)) - (TermW'(v) * TermW'(KGv));
        n_grp.term_b  = TermW'(u) * TermW'(KBu);
        n_grp.luma[0] = i_s_axis_tdata[15:8];
        n_grp.luma[1] = i_s_axis_tdata[31:24];
        n_grp.luma[2] = i_s_axis_tdata[39:32];
        n_grp.luma[3] = i_s_axis_tdata[47:40];
        n_grp.half    = i_half_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_grp_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp <= n_grp;
        end
    end

    assign o_grp_valid = r_valid;
    assign o_grp       = r_grp;

endmodule

FILE: hw/rtl/py411_queue.sv
// Two-entry queue of scaled groups between front end and pixel sequencer.
// Depends on py411_pkg.
module py411_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  py411_pkg::t_group i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output py411_pkg::t_group o_pop_data
);
    import py411_pkg::*;

    t_group            r_mem [QDepth];
    logic [QAddrW-1:0] r_wptr;
    logic [QAddrW-1:0] r_rptr;
    logic [QCntW-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCntW'(QDepth));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_data   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + QCntW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

FILE: hw/rtl/py411_back.sv
// Back end: walks the lumas of the head group into an output register, one
// pixel per cycle unless the receiver stalls. Depends on py411_pkg.
module py411_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_grp_valid,
    output logic                           o_grp_ready,
    input  py411_pkg::t_group              i_grp,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [py411_pkg::OutDataW-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);
    import py411_pkg::*;

    logic [PixIdxW-1:0]  r_idx;
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                r_out_last;

    logic                load;
    logic                last_pix;
    logic [LumaW-1:0]    y;
    logic signed [SumW-1:0] base;
    logic [OutDataW-1:0] n_out_data;

    assign load     = i_grp_valid && (!r_out_valid || i_m_axis_tready);
    assign last_pix = (r_idx == (i_grp.half ? LastHalf : LastFull));
    assign o_grp_ready = load && last_pix;

    assign y    = i_grp.luma[r_idx];
    assign base = $signed({{(SumW-LumaW-QShift){1'b0}}, y, {QShift{1'b0}}}) + QRound;

    always_comb begin
        n_out_data[7:0]   = clip_q12(base + SumW'(i_grp.term_r));
        n_out_data[15:8]  = clip_q12(base + SumW'(i_grp.term_g));
        n_out_data[23:16] = clip_q12(base + SumW'(i_grp.term_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= last_pix ? '0 : r_idx + PixIdxW'(1);
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= n_out_data;
            r_out_last <= last_pix;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: hw/rtl/packed_yuv411_to_rgb.sv
// Top level of the packed YUV 4:1:1 to RGB converter.
// Depends on py411_pkg, py411_front, py411_queue and py411_back.
//
// Usage:
//   Slave stream: one transaction per packed group U, Y0, V, Y1, Y2, Y3 (U and
//   V signed). Master stream: one transaction per RGB pixel, pixels in the
//   order Y0, Y1, Y2, Y3; tlast marks the final pixel of each group.
//   Config channel: one 1-bit register, half width mode. When set, a group
//   gives only the Y0 and Y1 pixels. Always ready; write it only while idle.
// Path: the first pixel of a group passes through the front register, the queue
//   and the output register before it is valid on the master stream.
// Throughput: the pixel sequencer emits one pixel per cycle unless the output
//   stalls, 4 pixels per group (2 in half width mode); the front end can
//   take a group every cycle until the two-entry queue fills.
// Reset (synchronous, active low): empties the front register, the queue and
//   the output register and clears half width mode.
// Stall: when the receiver holds tready low, the output register keeps its
//   pixel, the sequencer waits, and the queue and front register fill in
//   turn before tready on the slave side drops.
module packed_yuv411_to_rgb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: chroma_u[7:0], luma_0[15:8], chroma_v[23:16],
    //        luma_1[31:24], luma_2[39:32], luma_3[47:40]
    input  logic [py411_pkg::InDataW-1:0]  i_s_axis_tdata,
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16]
    output logic [py411_pkg::OutDataW-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast,  // last_of_group
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data       // half_width_mode
);
    import py411_pkg::*;

    logic   r_half_width;

    logic   fe_valid;
    logic   fe_ready;
    t_group fe_grp;

    logic   q_valid;
    logic   q_ready;
    t_group q_grp;

    // Config register; always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= 1'b0;
        end else if (i_cfg_valid) begin
            r_half_width <= i_cfg_data;
        end
    end

    // Front end: takes groups, forms the three chroma terms.
    py411_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_half_width    (r_half_width),
        .o_grp_valid     (fe_valid),
        .i_grp_ready     (fe_ready),
        .o_grp           (fe_grp)
    );

    // Short queue decouples the front end from the pixel sequencer.
    py411_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_data  (fe_grp),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_grp)
    );

    // Back end: one pixel per cycle into the output register unless it stalls.
    py411_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_grp_valid     (q_valid),
        .o_grp_ready     (q_ready),
        .i_grp           (q_grp),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: tb/tb_packed_yuv411_to_rgb.sv
// Self-checking testbench for packed_yuv411_to_rgb: drives packed 4:1:1 groups,
// predicts every RGB pixel in Q12 fixed point and checks the pixel stream.
// Depends on py411_pkg and the packed_yuv411_to_rgb RTL.
module tb_packed_yuv411_to_rgb;

    import py411_pkg::InDataW;
    import py411_pkg::OutDataW;

    localparam int HalfPeriod  = 6;
    localparam int ResetCycles = 11;
    localparam int IdlePct     = 9;      // percent of cycles a side idles
    localparam int DrainCycles = 10;     // a bit beyond the pipeline latency
    localparam int CycleLimit  = 200000;

    // Q12 coefficients of the color matrix
    localparam int KRedV   = 5743;
    localparam int KGreenU = 1411;
    localparam int KGreenV = 2925;
    localparam int KBlueU  = 7258;
    localparam int QRound  = 2048;
    localparam int QShift  = 12;

    // Config register values
    localparam bit ModeFull = 1'b0;
    localparam bit ModeHalf = 1'b1;

    typedef struct {
        logic signed [7:0] u;
        logic [7:0]        y0;
        logic signed [7:0] v;
        logic [7:0]        y1;
        logic [7:0]        y2;
        logic [7:0]        y3;
    } t_yuv_group;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_rgb_pixel;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [InDataW-1:0] i_s_axis_tdata;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [OutDataW-1:0] o_m_axis_tdata;
    logic               o_m_axis_tlast;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_data;

    // Pixels predicted for accepted groups, oldest first.
    t_rgb_pixel pending_pixels[$];
    bit         half_mode;        // our copy of half_width_mode
    bit         calm;             // no idling on either side while set
    int         mismatches;
    int         cycles;

    packed_yuv411_to_rgb i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #HalfPeriod i_clk = ~i_clk;

    // Run limit, far above the slowest correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Floor shift (arithmetic, toward minus infinity), then clip to a byte.
    function automatic logic [7:0] q12_to_byte(input int sum);
        int q;
        q = sum >>> QShift;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    // Expected pixel for one luma with the group's shared chroma.
    function automatic t_rgb_pixel yuv_to_rgb(input logic [7:0] y,
                                              input logic signed [7:0] u,
                                              input logic signed [7:0] v,
                                              input bit last);
        t_rgb_pixel px;
        int base, ui, vi;
        ui = u;                         // sign-extends
        vi = v;
        base = int'(y) * 4096 + QRound;
        px.red   = q12_to_byte(base + vi * KRedV);
        px.green = q12_to_byte(base - ui * KGreenU - vi * KGreenV);
        px.blue  = q12_to_byte(base + ui * KBlueU);
        px.last  = last;
        return px;
    endfunction

    // Receiver: tready idles at random except in calm stretches.
    always @(negedge i_clk) begin
        i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IdlePct);
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Checks every pixel transaction against the oldest prediction.
    always @(posedge i_clk) begin : check_pixels
        t_rgb_pixel want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %h last %b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                report_field("red",   want.red,   o_m_axis_tdata[7:0]);
                report_field("green", want.green, o_m_axis_tdata[15:8]);
                report_field("blue",  want.blue,  o_m_axis_tdata[23:16]);
                report_field("tlast", {7'd0, want.last}, {7'd0, o_m_axis_tlast});
            end
        end
    end

    // Sends one group and queues its pixels once the transaction happens.
    // tvalid stays high between back-to-back groups.
    task automatic send_group(input t_yuv_group g);
        int gap;
        logic [7:0] lumas [4];
        int count;
        gap = (!calm && $urandom_range(99) < IdlePct) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {g.y3, g.y2, g.y1, g.v, g.y0, g.u};
        do @(posedge i_clk); while (!o_s_axis_tready);
        lumas = '{g.y0, g.y1, g.y2, g.y3};
        count = half_mode ? 2 : 4;
        for (int k = 0; k < count; k++) begin
            pending_pixels.push_back(yuv_to_rgb(lumas[k], g.u, g.v, k == count - 1));
        end
    endtask

    task automatic stop_stream();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Config writes only while the block is idle.
    task automatic set_half_width(input bit mode);
        stop_stream();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        half_mode = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Extremes of luma and chroma, clipping at both ends, floor of negative
    // sums, and alternating bit patterns; reset mode gives four pixels.
    task automatic test_full_width_directed();
        send_group('{8'sh00, 8'h00, 8'sh00, 8'h00, 8'h00, 8'h00});
        send_group('{8'sh00, 8'hFF, 8'sh00, 8'h80, 8'h01, 8'h7F});
        send_group('{8'sh80, 8'h00, 8'sh80, 8'hFF, 8'h80, 8'h40});
        send_group('{8'sh7F, 8'h00, 8'sh7F, 8'hFF, 8'h80, 8'hC8});
        send_group('{8'sh80, 8'h00, 8'sh7F, 8'hFF, 8'h10, 8'hEB});
        send_group('{8'sh7F, 8'h00, 8'sh80, 8'hFF, 8'h10, 8'hEB});
        send_group('{8'sh55, 8'hAA, 8'shAA, 8'h55, 8'hAA, 8'h55});
        send_group('{8'shAA, 8'h55, 8'sh55, 8'hAA, 8'h55, 8'hAA});
        send_group('{8'sh01, 8'h00, 8'shFF, 8'h01, 8'hFE, 8'hFF});
        send_group('{8'shFF, 8'h00, 8'sh01, 8'h01, 8'hFE, 8'hFF});
    endtask

    // Half width: lumas 2 and 3 carry junk and must not show up.
    task automatic test_half_width_directed();
        set_half_width(ModeHalf);
        send_group('{8'sh00, 8'hFF, 8'sh00, 8'h00, 8'h12, 8'h34});
        send_group('{8'sh80, 8'h00, 8'sh7F, 8'hFF, 8'hFF, 8'hFF});
        send_group('{8'sh7F, 8'h80, 8'sh80, 8'h40, 8'hAA, 8'h55});
        send_group('{8'sh01, 8'h00, 8'shFF, 8'hFF, 8'h00, 8'h00});
        set_half_width(ModeHalf);      // rewrite of the same value
        send_group('{8'sh80, 8'hFF, 8'sh80, 8'h00, 8'h5A, 8'hA5});
        set_half_width(ModeFull);
        send_group('{8'sh7F, 8'hFF, 8'sh7F, 8'h00, 8'h5A, 8'hA5});
    endtask

    // Random groups in several register settings; a calm stretch in the
    // first phase runs both sides flat out.
    task automatic test_random_groups();
        bit modes [3];
        int counts [3];
        t_yuv_group g;
        modes  = '{ModeFull, ModeHalf, ModeFull};
        counts = '{78, 58, 58};
        for (int p = 0; p < 3; p++) begin
            set_half_width(modes[p]);
            for (int n = 0; n < counts[p]; n++) begin
                calm = (p == 0) && (n >= 20) && (n < 55);
                g.u  = 8'($urandom);
                g.y0 = 8'($urandom);
                g.v  = 8'($urandom);
                g.y1 = 8'($urandom);
                g.y2 = 8'($urandom);
                g.y3 = 8'($urandom);
                send_group(g);
            end
            calm = 1'b0;
        end
        stop_stream();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        half_mode       = ModeFull;
        calm            = 1'b0;
        mismatches      = 0;
        cycles          = 0;
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_width_directed();
        test_half_width_directed();
        test_random_groups();

        // Drain: all predicted pixels must arrive, and nothing after them.
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
